// ===== design/pbm_pkg.sv =====
// pbm_pkg: shared types and constants for the projective backward map
// no dependencies
package pbm_pkg;

   localparam int COORD_BITS = 11;
   localparam int COORD_W = COORD_BITS;
   localparam int COEF_W  = 32;
   localparam int CSR_W   = 64;
   localparam int IDX_W   = 3;

   localparam logic [IDX_W-1:0] REG_PAIR_A = 3'd0;
   localparam logic [IDX_W-1:0] REG_PAIR_B = 3'd1;
   localparam logic [IDX_W-1:0] REG_PAIR_C = 3'd2;
   localparam logic [IDX_W-1:0] REG_PAIR_D = 3'd3;
   localparam logic [IDX_W-1:0] REG_LAST   = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] dest_col;
      logic [COORD_W-1:0] dest_row;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] source_col;
      logic [COORD_W-1:0] source_row;
      logic               zero_divisor;
      logic               saturated;
   } rsp_type;

endpackage

// ===== design/pbm_div.sv =====
// pbm_div: pipelined restoring divider, one quotient bit per stage
// depends on pbm_pkg; quotient saturates at 2^QW - 1 via an overflow bit
module pbm_div #(
   parameter int NW = 56,
   parameter int QW = 11
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [NW-1:0] num,
   input  logic [NW-1:0] den,
   output logic [QW-1:0] quo,
   output logic          ovf
);
   import pbm_pkg::*;

   // overflow when num >= den << QW
   logic [NW+QW-1:0] lim;
   logic             big;
   assign lim = {den, {QW{1'b0}}};
   assign big = {{QW{1'b0}}, num} >= lim;

   logic [NW-1:0] rem   [QW];
   logic [NW-1:0] dvs   [QW];
   logic [QW-1:0] qpart [QW+1];
   logic          ovf_p [QW+1];

   assign rem[0]   = num;
   assign dvs[0]   = den;
   assign qpart[0] = '0;
   assign ovf_p[0] = big;

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int B = QW - 1 - s;
      logic [NW+QW-1:0] sh;
      logic             ge;
      logic [QW-1:0]    q_ff;
      logic             ovf_ff;
      assign sh = {{QW{1'b0}}, dvs[s]} << B;
      assign ge = {{QW{1'b0}}, rem[s]} >= sh;
      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff   <= qpart[s] | (QW'(ge) << B);
            ovf_ff <= ovf_p[s];
         end
      end
      assign qpart[s+1] = q_ff;
      assign ovf_p[s+1] = ovf_ff;

      if (s < QW - 1) begin : g_pass
         logic [NW-1:0] rem_ff, den_ff;
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff <= ge ? rem[s] - sh[NW-1:0] : rem[s];
               den_ff <= dvs[s];
            end
         end
         assign rem[s+1] = rem_ff;
         assign dvs[s+1] = den_ff;
      end
   end

   assign quo = qpart[QW];
   assign ovf = ovf_p[QW];
endmodule

// ===== design/projective_backward_map.sv =====
// projective_backward_map: maps one destination pixel to its source pixel
// through a 3x3 projective matrix; depends on pbm_pkg and pbm_div
// One item enters per clock while the pipeline advances. The stages are: one stage of
// coefficient products, one of sums, one of sign handling, COORD_BITS stages
// of the bit-per-stage divider, and the output register. The whole pipeline
// advances together and holds while the result is stalled with valid high.
module projective_backward_map (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pbm_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pbm_pkg::rsp_type     rsp_data,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_data
);
   import pbm_pkg::*;

   localparam int PW  = COEF_W + COORD_BITS + 1;
   localparam int SW  = PW + 2;
   localparam int NW  = SW - 1;
   localparam int DEP = COORD_BITS + 4;
   localparam logic [COORD_BITS-1:0] CMAX = '1;

   logic [CSR_W-1:0]  pa_ff, pb_ff, pc_ff, pd_ff;
   logic [COEF_W-1:0] last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_ff   <= 64'h0010_0000_0000_0000;
         pb_ff   <= '0;
         pc_ff   <= 64'h0010_0000_0000_0000;
         pd_ff   <= '0;
         last_ff <= 32'h0010_0000;
      end else if (csr_write) begin
         case (csr_index)
            REG_PAIR_A: pa_ff   <= csr_data;
            REG_PAIR_B: pb_ff   <= csr_data;
            REG_PAIR_C: pc_ff   <= csr_data;
            REG_PAIR_D: pd_ff   <= csr_data;
            REG_LAST:   last_ff <= csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic [DEP-1:0] vld_ff;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[DEP-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEP-2:0], req_valid};
      end
   end

   // stage 1: products
   logic signed [COORD_BITS:0] c_s, r_s;
   assign c_s = $signed({1'b0, req_data.dest_col[COORD_BITS-1:0]});
   assign r_s = $signed({1'b0, req_data.dest_row[COORD_BITS-1:0]});

   logic signed [PW-1:0] p11_ff, p12_ff, p21_ff, p22_ff, p31_ff, p32_ff;
   logic signed [COEF_W-1:0] k13_ff, k23_ff, k33_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         p11_ff <= $signed(pa_ff[63:32]) * c_s;
         p12_ff <= $signed(pa_ff[31:0]) * r_s;
         p21_ff <= $signed(pb_ff[31:0]) * c_s;
         p22_ff <= $signed(pc_ff[63:32]) * r_s;
         p31_ff <= $signed(pd_ff[63:32]) * c_s;
         p32_ff <= $signed(pd_ff[31:0]) * r_s;
         k13_ff <= $signed(pb_ff[63:32]);
         k23_ff <= $signed(pc_ff[31:0]);
         k33_ff <= $signed(last_ff);
      end
   end

   // stage 2: sums
   logic signed [SW-1:0] nx_ff, ny_ff, dn_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= SW'(p11_ff) + SW'(p12_ff) + SW'(k13_ff);
         ny_ff <= SW'(p21_ff) + SW'(p22_ff) + SW'(k23_ff);
         dn_ff <= SW'(p31_ff) + SW'(p32_ff) + SW'(k33_ff);
      end
   end

   // stage 3: magnitudes and sign clamp
   logic [NW-1:0] ax_ff, ay_ff, ad_ff;
   logic          zx_ff, zy_ff, zd_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff <= nx_ff[SW-1] ? NW'(-nx_ff) : NW'(nx_ff);
         ay_ff <= ny_ff[SW-1] ? NW'(-ny_ff) : NW'(ny_ff);
         ad_ff <= dn_ff[SW-1] ? NW'(-dn_ff) : NW'(dn_ff);
         zx_ff <= (nx_ff[SW-1] != dn_ff[SW-1]);
         zy_ff <= (ny_ff[SW-1] != dn_ff[SW-1]);
         zd_ff <= (dn_ff == '0);
      end
   end

   logic [COORD_BITS-1:0] qx, qy;
   logic                  ox, oy;
   logic [NW-1:0]         dsafe;
   assign dsafe = zd_ff ? NW'(1) : ad_ff;

   pbm_div #(.NW(NW), .QW(COORD_BITS)) u_div_x (
      .clock(clock), .adv(adv),
      .num(zx_ff ? '0 : ax_ff), .den(dsafe), .quo(qx), .ovf(ox));
   pbm_div #(.NW(NW), .QW(COORD_BITS)) u_div_y (
      .clock(clock), .adv(adv),
      .num(zy_ff ? '0 : ay_ff), .den(dsafe), .quo(qy), .ovf(oy));

   logic [COORD_BITS-1:0] zd_dly_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         zd_dly_ff <= {zd_dly_ff[COORD_BITS-2:0], zd_ff};
      end
   end

   // output stage
   logic zdo;
   rsp_type out_ff;
   assign zdo = zd_dly_ff[COORD_BITS-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.source_col   <= COORD_W'(zdo ? '0 : (ox ? CMAX : qx));
         out_ff.source_row   <= COORD_W'(zdo ? '0 : (oy ? CMAX : qy));
         out_ff.zero_divisor <= zdo;
         out_ff.saturated    <= !zdo && (ox || oy);
      end
   end
   assign rsp_data = out_ff;
endmodule

// ===== design/pbm_check.sv =====
// pbm_check: port-level checks on the projective backward map
// depends on pbm_pkg; bound to projective_backward_map
module pbm_check (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pbm_pkg::rsp_type rsp_data
);
   import pbm_pkg::*;

   a_stall_only_back: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall)) else $error("stall without back-pressure");
   a_zero_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_divisor) |->
      (rsp_data.source_col == '0 && rsp_data.source_row == '0 && !rsp_data.saturated))
      else $error("zero divisor item not cleared");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled item changed");
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid) else $error("item after reset");
endmodule

bind projective_backward_map pbm_check u_pbm_check (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

// ===== tb/tb.sv =====
// tb: self-checking bench for projective_backward_map, directed cases then random items
// depends on pbm_pkg and the design; predicts each source pixel and compares in order
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbm_pkg::*;

   localparam int LATENCY = COORD_W + 4;
   localparam int N_RAND = 550;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [63:0] ONE_Q = 64'd1048576;

   typedef struct {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               has_exp;
      rsp_type            exp;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_write = 0;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] coef_regs [0:4];
   rsp_type pixel_queue [$];
   rsp_type fixed_queue [$];
   logic fixed_flag_queue [$];
   int n_errors = 0;
   longint cycle_count = 0;
   int stall_left = 0;
   bit hold_off = 0;
   bit stim_done = 0;

   projective_backward_map i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic signed [63:0] coef(input int k);
      logic [31:0] w;
      w = (k % 2 == 0) ? coef_regs[k/2][63:32] : coef_regs[k/2][31:0];
      return {{32{w[31]}}, w};
   endfunction

   function automatic logic [COORD_W-1:0] divide_coord(input logic signed [63:0] num,
         input logic signed [63:0] den, inout logic sat);
      logic [63:0] q;
      if (num == 0 || ((num < 0) != (den < 0))) return '0;
      q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
      if (q > 64'd2047) begin
         sat = 1;
         return '1;
      end
      return q[COORD_W-1:0];
   endfunction

   function automatic rsp_type map_pixel(input logic [COORD_W-1:0] col,
         input logic [COORD_W-1:0] row);
      logic signed [63:0] c, r, nx, ny, den;
      logic sat;
      rsp_type o;
      c = {53'd0, col};
      r = {53'd0, row};
      nx = coef(0) * c + coef(1) * r + coef(2);
      ny = coef(3) * c + coef(4) * r + coef(5);
      den = coef(6) * c + coef(7) * r + $signed({{32{coef_regs[4][31]}}, coef_regs[4][31:0]});
      sat = 0;
      o = '0;
      if (den == 0) o.zero_divisor = 1;
      else begin
         o.source_col = divide_coord(nx, den, sat);
         o.source_row = divide_coord(ny, den, sat);
      end
      o.saturated = sat;
      return o;
   endfunction

   task automatic write_coef(input logic [2:0] idx, input logic [63:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      if (idx <= REG_LAST) coef_regs[idx] = (idx == REG_LAST) ? {32'd0, val[31:0]} : val;
      @(posedge clock);
   endtask

   task automatic drain_pipeline();
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
         input logic has_exp, input rsp_type exp);
      req_valid <= 1;
      req_data <= '{dest_col: col, dest_row: row};
      pixel_queue = {pixel_queue, map_pixel(col, row)};
      fixed_queue = {fixed_queue, exp};
      fixed_flag_queue = {fixed_flag_queue, has_exp};
      do @(posedge clock); while (req_stall);
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 2))
            @(posedge clock);
      end
   endtask

   function automatic logic [63:0] rand_pair(input int mode);
      case (mode)
         0: return {$urandom, $urandom};
         1: return {32'(int'($urandom_range(0, 4194304)) - 2097152),
                    32'(int'($urandom_range(0, 4194304)) - 2097152)};
         default: return {32'($urandom_range(0, 2048)), 32'($urandom_range(0, 2048))};
      endcase
   endfunction

   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else if (stim_done) rsp_stall <= 0;
      else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1;
         stall_left <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(5, 30))
                                                    : int'($urandom_range(0, 2));
      end else rsp_stall <= 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      logic has_fixed;
      rsp_type fixed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected item %h", rsp_data);
         end else begin
            want = pixel_queue.pop_front();
            fixed = fixed_queue.pop_front();
            has_fixed = fixed_flag_queue.pop_front();
            if (has_fixed && fixed !== want) want = fixed;
            if (rsp_data.source_col !== want.source_col
                || rsp_data.source_row !== want.source_row
                || rsp_data.zero_divisor !== want.zero_divisor
                || rsp_data.saturated !== want.saturated) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("item mismatch exp col %0d row %0d zd %b sat %b got %0d %0d %b %b",
                     want.source_col, want.source_row, want.zero_divisor, want.saturated,
                     rsp_data.source_col, rsp_data.source_row, rsp_data.zero_divisor,
                     rsp_data.saturated);
            end
         end
      end
   end

   initial begin
      stim_row_type table_rows [5];
      int phase;
      coef_regs[0] = 64'd4503599627370496;
      coef_regs[1] = 0;
      coef_regs[2] = 64'd4503599627370496;
      coef_regs[3] = 0;
      coef_regs[4] = ONE_Q;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // identity after reset
      table_rows[0] = '{0, 0, 1, '{0, 0, 0, 0}};
      table_rows[1] = '{2047, 2047, 1, '{2047, 2047, 0, 0}};
      table_rows[2] = '{2047, 0, 1, '{2047, 0, 0, 0}};
      table_rows[3] = '{0, 2047, 1, '{0, 2047, 0, 0}};
      table_rows[4] = '{1365, 682, 1, '{1365, 682, 0, 0}};
      foreach (table_rows[i])
         send_pixel(table_rows[i].col, table_rows[i].row,
                    table_rows[i].has_exp, table_rows[i].exp);
      req_valid <= 0;
      drain_pipeline();

      // zero divisor
      write_coef(REG_LAST, 0);
      send_pixel(5, 9, 1, '{0, 0, 1, 0});
      send_pixel(2047, 2047, 1, '{0, 0, 1, 0});
      req_valid <= 0;
      drain_pipeline();

      // scale by 2: saturation; negative divisor: clamp
      write_coef(REG_LAST, 64'd524288);
      send_pixel(2047, 3, 1, '{2047, 6, 0, 1});
      send_pixel(1000, 1023, 1, '{2000, 2046, 0, 0});
      send_pixel(1024, 0, 1, '{2047, 0, 0, 1});
      req_valid <= 0;
      drain_pipeline();
      write_coef(REG_LAST, 64'hFFFF_FFFF_FFF0_0000);
      send_pixel(7, 11, 1, '{0, 0, 0, 0});
      send_pixel(0, 0, 1, '{0, 0, 0, 0});
      req_valid <= 0;
      drain_pipeline();

      // extreme coefficients, projective term, unknown index
      write_coef(REG_PAIR_A, 64'h7FFF_FFFF_8000_0000);
      write_coef(REG_PAIR_B, 64'h8000_0000_7FFF_FFFF);
      write_coef(REG_PAIR_C, 64'hFFFF_FFFF_0000_0001);
      write_coef(REG_PAIR_D, 64'h0000_0400_FFFF_FC00);
      write_coef(REG_LAST, 64'h0000_0000_7FFF_FFFF);
      write_coef(3'd6, 64'hDEAD_BEEF_0123_4567);
      foreach (table_rows[i]) send_pixel(table_rows[i].col, table_rows[i].row, 0, '0);
      send_pixel(1, 2047, 0, '0);
      req_valid <= 0;
      drain_pipeline();

      for (phase = 0; phase < 6; phase++) begin
         write_coef(REG_PAIR_A, rand_pair(phase % 3));
         write_coef(REG_PAIR_B, rand_pair((phase + 1) % 3));
         write_coef(REG_PAIR_C, rand_pair(phase % 3));
         write_coef(REG_PAIR_D, (phase % 2) ? rand_pair(2) & 64'h0000_00FF_0000_00FF : 64'd0);
         write_coef(REG_LAST, phase == 5 ? 64'h8000_0000 : {32'd0, 32'($urandom_range(1, 1 << 22))});
         if (phase == 2) begin
            fork
               begin
                  hold_off = 1;
                  repeat (200) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         repeat (N_RAND / 6) begin
            if ($urandom_range(0, 9) == 0)
               send_pixel($urandom_range(0, 1) ? 11'h7FF : 11'h0, 11'($urandom), 0, '0);
            else
               send_pixel(11'($urandom), 11'($urandom), 0, '0);
         end
         req_valid <= 0;
         drain_pipeline();
      end

      stim_done = 1;
      if (n_errors == 0 && pixel_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
